### hw/rtl/sls_pkg.sv
// Shared types and constants for the scrolling LED column scanner.
`default_nettype none

package sls_pkg;

    localparam int MATRIX_COLUMNS = 32;
    localparam int STORE_DEPTH    = 1024;
    localparam int STORE_AW       = $clog2(STORE_DEPTH);
    localparam int POS_W          = 10;
    localparam int COUNT_W        = 6;
    localparam int PHASE_W        = 3;
    localparam int ROW_W          = 8;
    localparam int WIN_W          = POS_W + 1;

    localparam logic [PHASE_W-1:0] PHASE_DRIVE = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_BLANK = 3'd4;
    localparam logic [PHASE_W-1:0] PHASE_LAST  = 3'd5;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_WRITE  = 2'd1,
        FUNC_SCROLL = 2'd2,
        FUNC_END    = 2'd3
    } sls_func_t;

    typedef struct packed {
        logic drive;
        logic blank;
        logic clock_level;
        logic reset_pulse;
        logic new_message;
    } sls_flags_t;

endpackage

`default_nettype wire

### hw/rtl/sls_store.sv
// Column store memory with a clearing sweep after reset.
`default_nettype none

module sls_store (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire logic [sls_pkg::STORE_AW-1:0] wr_addr,
    input  wire logic [sls_pkg::ROW_W-1:0]    wr_data,
    input  wire logic                        rd_en,
    input  wire logic [sls_pkg::STORE_AW-1:0] rd_addr,
    output logic      [sls_pkg::ROW_W-1:0]    rd_data,
    output logic                             clearing
);
    import sls_pkg::*;

    logic [ROW_W-1:0]    mem [STORE_DEPTH];
    logic                clearing_reg;
    logic                clearing_next;
    logic [STORE_AW-1:0] clr_addr_reg;
    logic [STORE_AW-1:0] clr_addr_next;
    logic                mem_we;
    logic [STORE_AW-1:0] mem_waddr;
    logic [ROW_W-1:0]    mem_wdata;

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + STORE_AW'(1);
            if (clr_addr_reg == STORE_AW'(STORE_DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign mem_we    = clearing_reg || wr_en;
    assign mem_waddr = clearing_reg ? clr_addr_reg : wr_addr;
    assign mem_wdata = clearing_reg ? '0 : wr_data;
    assign clearing  = clearing_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/sls_ctrl.sv
// Phase sequencer, column counter and scroll window state.
`default_nettype none

module sls_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire logic [1:0]                   func,
    input  wire logic [sls_pkg::POS_W-1:0]    end_position,
    output logic      [sls_pkg::STORE_AW-1:0] rd_addr,
    output sls_pkg::sls_flags_t               flags
);
    import sls_pkg::*;

    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [PHASE_W-1:0] phase_inc;
    logic [COUNT_W-1:0] column_count_reg;
    logic [COUNT_W-1:0] column_count_next;
    logic [POS_W-1:0]   scroll_start_reg;
    logic [POS_W-1:0]   scroll_start_next;
    logic [POS_W-1:0]   start_inc;
    logic               scroll_pending_reg;
    logic               scroll_pending_next;
    logic [POS_W-1:0]   restart_reg;
    logic [POS_W-1:0]   restart_next;
    logic               clock_level_reg;
    logic               clock_level_next;
    logic [POS_W-1:0]   read_pos;

    assign phase_inc = phase_reg + PHASE_W'(1);
    assign start_inc = scroll_start_reg + POS_W'(1);
    assign read_pos  = scroll_start_reg + POS_W'(column_count_reg);
    assign rd_addr   = read_pos[STORE_AW-1:0];

    always_comb
    begin
        phase_next          = phase_reg;
        column_count_next   = column_count_reg;
        scroll_start_next   = scroll_start_reg;
        scroll_pending_next = scroll_pending_reg;
        restart_next        = restart_reg;
        clock_level_next    = clock_level_reg;
        flags               = '0;
        if (accept)
        begin
            unique case (sls_func_t'(func))
                FUNC_TICK:
                begin
                    phase_next = phase_inc;
                    if (phase_inc == PHASE_DRIVE)
                    begin
                        clock_level_next  = 1'b1;
                        flags.drive       = 1'b1;
                        column_count_next = column_count_reg + COUNT_W'(1);
                    end
                    else if (phase_inc == PHASE_BLANK)
                    begin
                        clock_level_next = 1'b0;
                        flags.blank      = 1'b1;
                    end
                    else if (phase_inc == PHASE_LAST)
                    begin
                        phase_next = '0;
                        if (column_count_reg == COUNT_W'(MATRIX_COLUMNS))
                        begin
                            flags.reset_pulse = 1'b1;
                            clock_level_next  = 1'b0;
                            column_count_next = '0;
                            if (scroll_pending_reg)
                            begin
                                scroll_pending_next = 1'b0;
                                // window end compared without wrap
                                if ({1'b0, start_inc} + WIN_W'(MATRIX_COLUMNS)
                                    == {1'b0, restart_reg})
                                begin
                                    scroll_start_next = '0;
                                    flags.new_message = 1'b1;
                                end
                                else
                                begin
                                    scroll_start_next = start_inc;
                                end
                            end
                        end
                    end
                end
                FUNC_WRITE:
                begin
                end
                FUNC_SCROLL:
                begin
                    scroll_pending_next = 1'b1;
                end
                FUNC_END:
                begin
                    restart_next = end_position;
                end
                default:
                begin
                end
            endcase
        end
        flags.clock_level = clock_level_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= '0;
            column_count_reg   <= '0;
            scroll_start_reg   <= '0;
            scroll_pending_reg <= 1'b0;
            restart_reg        <= '0;
            clock_level_reg    <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            column_count_reg   <= column_count_next;
            scroll_start_reg   <= scroll_start_next;
            scroll_pending_reg <= scroll_pending_next;
            restart_reg        <= restart_next;
            clock_level_reg    <= clock_level_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/scrolling_led_column_scanner.sv
// Scrolling LED column scanner: top level with item and result registers.
// Latency: a result passes from the stage-1 flag register and the store read port into the output register.
// Throughput: one transaction per cycle while in_ready is high; the column store reads one column per
// transaction on its registered read port.
// Reset: control state clears at once; the 1024-entry column store is then
// swept to zero entry by entry, during which in_ready stays low.
`default_nettype none

module scrolling_led_column_scanner (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [1:0]                func,
    input  wire logic [9:0]                column_addr,
    input  wire logic [7:0]                column_data,
    input  wire logic [9:0]                end_position,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic      [7:0]                row_bits,
    output logic                           column_clock,
    output logic                           reset_pulse,
    output logic                           new_message
);
    import sls_pkg::*;

    logic                accept;
    logic                clearing;
    logic                wr_en;
    logic [STORE_AW-1:0] rd_addr;
    logic [ROW_W-1:0]    rd_data;
    sls_flags_t          flags;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    sls_flags_t          s1_flags_reg;
    logic                s1_move;
    logic                out_free;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [ROW_W-1:0]    row_bits_reg;
    logic [ROW_W-1:0]    row_bits_next;
    logic                clock_reg;
    logic                rst_pulse_reg;
    logic                new_msg_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_ready = !clearing && (!s1_valid_reg || out_free);
    assign accept   = in_valid && in_ready;
    assign wr_en    = accept && (sls_func_t'(func) == FUNC_WRITE);

    sls_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (column_addr[STORE_AW-1:0]),
        .wr_data  (column_data),
        .rd_en    (accept),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .clearing (clearing)
    );

    sls_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .func         (func),
        .end_position (end_position),
        .rd_addr      (rd_addr),
        .flags        (flags)
    );

    always_comb
    begin
        s1_valid_next = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_move ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        // row levels live in the output register; they hold across other transactions
        priority if (s1_flags_reg.drive)
        begin
            row_bits_next = rd_data;
        end
        else if (s1_flags_reg.blank)
        begin
            row_bits_next = '0;
        end
        else
        begin
            row_bits_next = row_bits_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_flags_reg  <= '0;
            out_valid_reg <= 1'b0;
            row_bits_reg  <= '0;
            clock_reg     <= 1'b0;
            rst_pulse_reg <= 1'b0;
            new_msg_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                s1_flags_reg <= flags;
            end
            if (s1_move)
            begin
                row_bits_reg  <= row_bits_next;
                clock_reg     <= s1_flags_reg.clock_level;
                rst_pulse_reg <= s1_flags_reg.reset_pulse;
                new_msg_reg   <= s1_flags_reg.new_message;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign row_bits     = row_bits_reg;
    assign column_clock = clock_reg;
    assign reset_pulse  = rst_pulse_reg;
    assign new_message  = new_msg_reg;

endmodule

`default_nettype wire

### hw/rtl/sls_checker.sv
// Port-level checks for the scrolling LED column scanner, bound to the top level.
`default_nettype none

module sls_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] row_bits,
    input wire logic       column_clock,
    input wire logic       reset_pulse,
    input wire logic       new_message
);

    // a scroll wrap only happens at the end of a frame
    a_msg_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && new_message |-> reset_pulse)
        else $error("new_message without reset_pulse");

    // the frame ends after the blank phase, so the matrix is dark
    a_dark_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reset_pulse |-> !column_clock && (row_bits == 8'd0))
        else $error("rows or clock active at frame end");

    // rows are only lit while the column clock is high
    a_rows_need_clock: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !column_clock |-> (row_bits == 8'd0))
        else $error("rows lit with column clock low");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(row_bits)
            && $stable(column_clock))
        else $error("stalled result changed");

endmodule

bind scrolling_led_column_scanner sls_checker u_sls_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .row_bits     (row_bits),
    .column_clock (column_clock),
    .reset_pulse  (reset_pulse),
    .new_message  (new_message)
);

`default_nettype wire
